/* src/assert_macros.svh */
// Assertion helpers for line_overlap_grid_counter_unit.
// They assume the including module has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition is never true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

/* src/lovc_pkg.sv */
package lovc_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned HIT_W = 2;
  localparam int unsigned GRID_SIDE_DEF = 1024;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [HIT_W-1:0] HIT_NONE = 2'd0;
  localparam logic [HIT_W-1:0] HIT_ONE = 2'd1;
  localparam logic [HIT_W-1:0] HIT_SAT = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] overlap_cells;
    logic               segment_drawn;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_REPORT
  } state_e;

endpackage

/* src/line_overlap_grid_counter_unit.sv */
// A drawn segment with n = max(|dx|, |dy|) is handled in states RUN, DRAIN and REPORT:
// one grid read a cycle over its n + 1 cells, a write-back of the last cell and
// the report. An ignored segment goes straight to the report.
// After reset the grid memory is cleared one cell a cycle, all 2**(2*ceil(log2(GRID_SIDE)))
// cells, while input transactions are stalled. The overlap count resets to 0.
`include "assert_macros.svh"

module line_overlap_grid_counter_unit #(
  parameter int unsigned GRID_SIDE = lovc_pkg::GRID_SIDE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lovc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lovc_pkg::out_t  out_data_o
);

  localparam int unsigned CW = $clog2(GRID_SIDE);
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned XW = lovc_pkg::COORD_W;

  lovc_pkg::state_e state_q, state_d;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_last;

  logic [XW-1:0] cur_x_q, cur_x_d;
  logic [XW-1:0] cur_y_q, cur_y_d;
  logic [XW-1:0] remain_q, remain_d;
  logic          x_inc_q, x_inc_d;
  logic          y_inc_q, y_inc_d;
  logic          y_dec_q, y_dec_d;
  logic          drawn_q, drawn_d;

  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;

  logic [lovc_pkg::COUNT_W-1:0] overlap_total_q, overlap_total_d;

  logic           out_valid_q, out_valid_d;
  lovc_pkg::out_t out_data_q, out_data_d;

  logic [XW-1:0] xa, ya, xb, yb, dx, dy, span;
  logic          swap, y_up, drawn;

  logic                      in_range, rd_en, ram_we;
  logic [AW-1:0]             rd_addr, ram_waddr;
  logic [lovc_pkg::HIT_W-1:0] ram_rdata, ram_wdata;

  logic accept, issue_rd, clearing, load_out, out_free;

  // Endpoint ordering and slope classification.
  always_comb begin
    swap = (in_data_i.x_start > in_data_i.x_end) ||
           ((in_data_i.x_start == in_data_i.x_end) && (in_data_i.y_start > in_data_i.y_end));
    xa = swap ? in_data_i.x_end : in_data_i.x_start;
    ya = swap ? in_data_i.y_end : in_data_i.y_start;
    xb = swap ? in_data_i.x_start : in_data_i.x_end;
    yb = swap ? in_data_i.y_start : in_data_i.y_end;
    dx = xb - xa;
    y_up = yb > ya;
    dy = y_up ? (yb - ya) : (ya - yb);
    drawn = (dx == '0) || (dy == '0) || (dx == dy);
    span = (dx > dy) ? dx : dy;
  end

  assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lovc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = lovc_pkg::ST_IDLE;
        end
      end
      lovc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = drawn ? lovc_pkg::ST_RUN : lovc_pkg::ST_REPORT;
        end
      end
      lovc_pkg::ST_RUN: begin
        if (remain_q == '0) begin
          state_d = lovc_pkg::ST_DRAIN;
        end
      end
      lovc_pkg::ST_DRAIN: begin
        state_d = lovc_pkg::ST_REPORT;
      end
      lovc_pkg::ST_REPORT: begin
        if (out_free) begin
          state_d = lovc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lovc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    issue_rd   = 1'b0;
    clearing   = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      lovc_pkg::ST_CLEAR:  clearing   = 1'b1;
      lovc_pkg::ST_IDLE:   in_stall_o = 1'b0;
      lovc_pkg::ST_RUN:    issue_rd   = 1'b1;
      lovc_pkg::ST_DRAIN:  issue_rd   = 1'b0;
      lovc_pkg::ST_REPORT: load_out   = out_free;
      default:             in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // Walk along the segment, one cell per cycle.
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    remain_d = remain_q;
    x_inc_d  = x_inc_q;
    y_inc_d  = y_inc_q;
    y_dec_d  = y_dec_q;
    drawn_d  = drawn_q;
    if (accept) begin
      cur_x_d  = xa;
      cur_y_d  = ya;
      remain_d = span;
      x_inc_d  = dx != '0;
      y_inc_d  = (dy != '0) && y_up;
      y_dec_d  = (dy != '0) && !y_up;
      drawn_d  = drawn;
    end else if (issue_rd) begin
      cur_x_d  = cur_x_q + XW'(x_inc_q);
      cur_y_d  = cur_y_q + XW'(y_inc_q) - XW'(y_dec_q);
      remain_d = remain_q - XW'(1);
    end
  end

  assign in_range = (int'(cur_x_q) < int'(GRID_SIDE)) && (int'(cur_y_q) < int'(GRID_SIDE));
  assign rd_addr  = {CW'(cur_y_q), CW'(cur_x_q)};
  assign rd_en    = issue_rd && in_range;

  assign rd_pend_d = rd_en;
  assign wr_addr_d = rd_en ? rd_addr : wr_addr_q;
  assign clr_cnt_d = clearing ? (clr_cnt_q + AW'(1)) : clr_cnt_q;

  // Write-back of the cell read in the previous cycle; cells of one segment are distinct.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = wr_addr_q;
    ram_wdata       = ram_rdata + lovc_pkg::HIT_W'(1);
    overlap_total_d = overlap_total_q;
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = lovc_pkg::HIT_NONE;
    end else if (rd_pend_q && (ram_rdata != lovc_pkg::HIT_SAT)) begin
      ram_we = 1'b1;
      if ((ram_rdata == lovc_pkg::HIT_ONE) && (overlap_total_q != lovc_pkg::COUNT_MAX)) begin
        overlap_total_d = overlap_total_q + lovc_pkg::COUNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d              = 1'b1;
      out_data_d.overlap_cells = overlap_total_q;
      out_data_d.segment_drawn = drawn_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  lovc_ram #(
    .WIDTH(lovc_pkg::HIT_W),
    .DEPTH(DEPTH)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= lovc_pkg::ST_CLEAR;
      clr_cnt_q       <= '0;
      rd_pend_q       <= 1'b0;
      overlap_total_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      clr_cnt_q       <= clr_cnt_d;
      rd_pend_q       <= rd_pend_d;
      overlap_total_q <= overlap_total_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    remain_q   <= remain_d;
    x_inc_q    <= x_inc_d;
    y_inc_q    <= y_inc_d;
    y_dec_q    <= y_dec_d;
    drawn_q    <= drawn_d;
    wr_addr_q  <= wr_addr_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_PROP(a_total_monotonic, 1'b1 |=> (overlap_total_q >= $past(overlap_total_q)), "overlap count decreased")
  `ASSERT_PROP(a_pend_in_walk, rd_pend_q |-> (state_q == lovc_pkg::ST_RUN || state_q == lovc_pkg::ST_DRAIN), "grid write-back outside a segment walk")
  `ASSERT_PROP(a_load_from_report, $rose(out_valid_q) |-> ($past(state_q) == lovc_pkg::ST_REPORT), "result loaded outside report state")
  `ASSERT_NEVER(a_no_accept_clear, accept && clearing, "transaction accepted during grid clear")
  `ASSERT_NEVER(a_clear_collide, clearing && rd_pend_q, "grid clear overlaps a write-back")

endmodule

/* src/lovc_ram.sv */
module lovc_ram #(
  parameter int unsigned WIDTH = lovc_pkg::HIT_W,
  parameter int unsigned DEPTH = lovc_pkg::GRID_SIDE_DEF * lovc_pkg::GRID_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* tb/sv/overlap_count_checker.sv */
`timescale 1ns / 1ps

module overlap_count_checker
  import lovc_pkg::*;
#(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned awaiting_o
);

  bit   [HIT_W-1:0]   hit_map [GRID_SIDE*GRID_SIDE];
  logic [COUNT_W-1:0] overlap_running;
  out_t               expected_reports [$];

  // Walks every cell of an accepted drawn segment, updates the shadow grid and returns the expected report.
  function automatic out_t rasterize_segment(in_t seg);
    int   xa, ya, xb, yb, tmp;
    int   dx, dy, steps, dir_y, cx, cy, i;
    int   unsigned idx;
    out_t rep;
    xa = seg.x_start;
    ya = seg.y_start;
    xb = seg.x_end;
    yb = seg.y_end;
    if (xa > xb || (xa == xb && ya > yb)) begin
      tmp = xa; xa = xb; xb = tmp;
      tmp = ya; ya = yb; yb = tmp;
    end
    dx = xb - xa;
    dy = (yb >= ya) ? yb - ya : ya - yb;
    rep.segment_drawn = (dx == 0) || (dy == 0) || (dx == dy);
    if (rep.segment_drawn) begin
      steps = (dx > dy) ? dx : dy;
      dir_y = (dy == 0) ? 0 : ((yb > ya) ? 1 : -1);
      for (i = 0; i <= steps; i++) begin
        cx = (dx == 0) ? xa : xa + i;
        cy = ya + dir_y * i;
        if (cx < GRID_SIDE && cy < GRID_SIDE) begin
          idx = cy * GRID_SIDE + cx;
          if (hit_map[idx] != HIT_SAT) begin
            hit_map[idx] = hit_map[idx] + 1'b1;
            if (hit_map[idx] == HIT_SAT && overlap_running != COUNT_MAX) begin
              overlap_running = overlap_running + 1'b1;
            end
          end
        end
      end
    end
    rep.overlap_cells = overlap_running;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      foreach (hit_map[k]) hit_map[k] = HIT_NONE;
      overlap_running = '0;
      expected_reports.delete();
      fail_count_o = 0;
      awaiting_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_reports.push_back(rasterize_segment(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("Result transaction arrived with no segment outstanding.");
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data_i.overlap_cells !== want.overlap_cells) begin
            $error("overlap_cells: expected %0d, actual %0d",
                   want.overlap_cells, out_data_i.overlap_cells);
            fail_count_o++;
          end
          if (out_data_i.segment_drawn !== want.segment_drawn) begin
            $error("segment_drawn: expected %0d, actual %0d",
                   want.segment_drawn, out_data_i.segment_drawn);
            fail_count_o++;
          end
        end
      end
      awaiting_o = expected_reports.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lovc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned RANDOM_ITEMS = 580;
  localparam int unsigned CLUSTER_SPAN = 48;
  localparam int unsigned DIRECTED_ITEMS = 20;

  typedef enum int {
    DIR_ROW,
    DIR_COLUMN,
    DIR_RISING,
    DIR_FALLING
  } dir_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned awaiting;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          idling = 1'b1;

  int directed_pts [DIRECTED_ITEMS][4] = '{
    '{0, 0, 0, 0},
    '{0, 0, 0, 0},
    '{0, 0, 1023, 0},
    '{1023, 1023, 1023, 0},
    '{0, 0, 1023, 1023},
    '{1023, 0, 0, 1023},
    '{0, 1023, 1023, 0},
    '{1023, 1023, 0, 1},
    '{0, 0, 1, 2},
    '{1, 2, 0, 0},
    '{10, 20, 10, 5},
    '{10, 5, 10, 20},
    '{100, 100, 110, 100},
    '{105, 95, 105, 105},
    '{100, 95, 110, 105},
    '{30, 20, 20, 30},
    '{20, 30, 30, 20},
    '{1023, 1023, 1023, 1023},
    '{341, 682, 682, 341},
    '{682, 341, 341, 682}
  };

  line_overlap_grid_counter_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  overlap_count_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[line_overlap_grid_counter_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      hold_cycles = idling ? $urandom_range(0, 14) : 0;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_t segment_of(int xa, int ya, int xb, int yb);
    in_t seg;
    seg.x_start = xa[COORD_W-1:0];
    seg.y_start = ya[COORD_W-1:0];
    seg.x_end   = xb[COORD_W-1:0];
    seg.y_end   = yb[COORD_W-1:0];
    return seg;
  endfunction

  // Builds a drawable segment that fits inside a square window.
  function automatic in_t random_segment(int bx, int by, int span, int max_len);
    dir_e dir;
    int   len, sx, sy, x0, y0;
    dir = dir_e'($urandom_range(0, 3));
    len = $urandom_range(0, max_len);
    sx = (dir == DIR_COLUMN) ? 0 : 1;
    sy = (dir == DIR_ROW) ? 0 : ((dir == DIR_FALLING) ? -1 : 1);
    x0 = bx + $urandom_range(0, span - 1 - len * sx);
    y0 = by + ((sy < 0) ? len : 0) + $urandom_range(0, span - 1 - len * sy * sy);
    if ($urandom_range(0, 1)) begin
      return segment_of(x0 + len * sx, y0 + len * sy, x0, y0);
    end
    return segment_of(x0, y0, x0 + len * sx, y0 + len * sy);
  endfunction

  task automatic send_segment(input in_t seg);
    int gap;
    gap = idling ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  initial begin
    in_t         seg;
    int          bx, by, pick, n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    bx = 0;
    by = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_ITEMS; n++) begin
      send_segment(segment_of(directed_pts[n][0], directed_pts[n][1],
                              directed_pts[n][2], directed_pts[n][3]));
    end
    drain_reports();
    @(negedge clk);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        bx = $urandom_range(0, GRID_SIDE_DEF - CLUSTER_SPAN);
        by = $urandom_range(0, GRID_SIDE_DEF - CLUSTER_SPAN);
      end
      idling = ((n / 90) % 3) != 2;
      if (n == RANDOM_ITEMS / 2) begin
        drain_reports();
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        seg = random_segment(bx, by, CLUSTER_SPAN, 15);
      end else if (pick < 81) begin
        seg = random_segment(0, 0, GRID_SIDE_DEF, GRID_SIDE_DEF - 1);
      end else if (pick < 90) begin
        seg = segment_of(bx + $urandom_range(0, CLUSTER_SPAN - 1),
                         by + $urandom_range(0, CLUSTER_SPAN - 1),
                         bx + $urandom_range(0, CLUSTER_SPAN - 1),
                         by + $urandom_range(0, CLUSTER_SPAN - 1));
      end else begin
        seg = segment_of($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      send_segment(seg);
    end

    drain_reports();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("[line_overlap_grid_counter_unit] OK");
    end else begin
      $display("[line_overlap_grid_counter_unit] ERROR");
    end
    $finish;
  end

endmodule

/* line_overlap_grid_counter_unit.f */
+incdir+src
src/lovc_pkg.sv
src/lovc_ram.sv
src/line_overlap_grid_counter_unit.sv
tb/sv/overlap_count_checker.sv
tb/sv/testbench.sv
